// ----- design/sawt_pkg.sv -----
// Shared types and constants of the selective-ack window tracker.
package sawt_pkg;

  localparam int SLOT_W      = 5;
  localparam int NUM_SLOTS   = 32;
  localparam int SEQ_W       = 32;
  localparam int SEQ_LOW_W   = 9;
  localparam int CNT_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int KIND_W      = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [SEQ_LOW_W-1:0] WINDOW_SPAN       = 9'd30;
  localparam logic [SEQ_W-1:0]     LAST_SEQ_MAX      = 32'hFFFF_FFFF - 32'd30;
  localparam logic [CNT_W-1:0]     RUN_MAX           = 3'd7;
  localparam logic [SLOT_W-1:0]    SCAN_SLOTS        = 5'd31;
  localparam logic [SLOT_W-1:0]    SCAN_FIRST_OFFSET = 5'd2;
  localparam logic [SLOT_W-1:0]    ACK_THRESH_RESET  = 5'd11;

  localparam logic [CFG_INDEX_W-1:0] CFG_CONN_PARITY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_THRESH  = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW      = 3'd0,
    ST_DUP      = 3'd1,
    ST_BAD_CONN = 3'd2,
    ST_OUT_WIN  = 3'd3,
    ST_RUN      = 3'd4,
    ST_TERM     = 3'd5
  } status_t;

  typedef struct packed {
    logic capture;
    logic rx_check;
    logic rx_apply;
    logic scan_step;
    logic term;
  } sawt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_emit;
    logic scan_last;
  } sawt_sts_t;

endpackage

// ----- design/selective_ack_window_tracker.sv -----
// Top level of the selective-ack window tracker.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   input    | in_valid / in_stall  | action seq_low partner_high_ack conn_bit flags
//            |                      | header_kind
//   output   | out_valid / out_stall| status ack_back run_count run_start kind_out last
//   config   | cfg_valid / cfg_ready| cfg_index cfg_data
//
// A receive beat steps through accept, window check, then map update into the result register.
// A build beat steps through accept, one scan step per slot for 31 slots, then the terminator.
// A stalled result register holds the scan or update step until it drains.
// Reset clears the ack map, the last sequence number and loads the register defaults.
module selective_ack_window_tracker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sawt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sawt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [sawt_pkg::SEQ_LOW_W-1:0]       seq_low,
  input  logic [sawt_pkg::SLOT_W-1:0]          partner_high_ack,
  input  logic                                 conn_bit,
  input  logic                                 is_ping,
  input  logic                                 is_resend,
  input  logic                                 is_ack_flag,
  input  logic                                 is_accept,
  input  logic [sawt_pkg::KIND_W-1:0]          header_kind,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sawt_pkg::STATUS_W-1:0]        status,
  output logic                                 ack_back,
  output logic [sawt_pkg::CNT_W-1:0]           run_count,
  output logic [sawt_pkg::SLOT_W-1:0]          run_start,
  output logic [sawt_pkg::KIND_W-1:0]          kind_out,
  output logic                                 last
);

  sawt_pkg::sawt_cmd_t cmd;
  sawt_pkg::sawt_sts_t sts;

  assign cfg_ready = 1'b1;

  sawt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sawt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .seq_low          (seq_low),
    .partner_high_ack (partner_high_ack),
    .conn_bit         (conn_bit),
    .is_ping          (is_ping),
    .is_resend        (is_resend),
    .is_ack_flag      (is_ack_flag),
    .is_accept        (is_accept),
    .header_kind      (header_kind),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .status           (status),
    .ack_back         (ack_back),
    .run_count        (run_count),
    .run_start        (run_start),
    .kind_out         (kind_out),
    .last             (last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ----- design/sawt_ctrl.sv -----
// Controller state machine of the selective-ack window tracker.
module sawt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  action,
  output logic                  in_stall,
  input  sawt_pkg::sawt_sts_t   sts,
  output sawt_pkg::sawt_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_RX_CHECK = 5'b00010,
    S_RX_APPLY = 5'b00100,
    S_SCAN     = 5'b01000,
    S_TERM     = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = action ? S_SCAN : S_RX_CHECK;
        end
      end
      S_RX_CHECK: begin
        cmd.rx_check = 1'b1;
        state_next   = S_RX_APPLY;
      end
      S_RX_APPLY: begin
        if (sts.out_free) begin
          cmd.rx_apply = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!sts.scan_emit || sts.out_free) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_next = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (sts.out_free) begin
          cmd.term   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/sawt_dp.sv -----
// Datapath of the selective-ack window tracker: window state, scan and result register.
module sawt_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [sawt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sawt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [sawt_pkg::SEQ_LOW_W-1:0]       seq_low,
  input  logic [sawt_pkg::SLOT_W-1:0]          partner_high_ack,
  input  logic                                 conn_bit,
  input  logic                                 is_ping,
  input  logic                                 is_resend,
  input  logic                                 is_ack_flag,
  input  logic                                 is_accept,
  input  logic [sawt_pkg::KIND_W-1:0]          header_kind,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [sawt_pkg::STATUS_W-1:0]        status,
  output logic                                 ack_back,
  output logic [sawt_pkg::CNT_W-1:0]           run_count,
  output logic [sawt_pkg::SLOT_W-1:0]          run_start,
  output logic [sawt_pkg::KIND_W-1:0]          kind_out,
  output logic                                 last,
  input  sawt_pkg::sawt_cmd_t                  cmd,
  output sawt_pkg::sawt_sts_t                  sts
);

  // configuration
  logic                        connection_parity;
  logic [sawt_pkg::SLOT_W-1:0] ack_back_threshold;

  // window state
  logic [sawt_pkg::NUM_SLOTS-1:0] ack_map;
  logic [sawt_pkg::SEQ_W-1:0]     last_seq;

  // captured beat
  logic [sawt_pkg::SEQ_LOW_W-1:0] in_seq;
  logic [sawt_pkg::SLOT_W-1:0]    in_high_ack;
  logic                           in_conn;
  logic                           in_ping;
  logic                           in_resend;
  logic                           in_ackf;
  logic                           in_accept;
  logic [sawt_pkg::KIND_W-1:0]    in_kind;

  // check results
  sawt_pkg::status_t              rx_code;
  logic [sawt_pkg::SLOT_W-1:0]    rx_diff;

  // scan state
  logic [sawt_pkg::NUM_SLOTS-1:0] scan_map;
  logic [sawt_pkg::SLOT_W-1:0]    scan_pos;
  logic [sawt_pkg::SLOT_W-1:0]    scan_rem;
  logic [sawt_pkg::CNT_W-1:0]     run_len;
  logic [sawt_pkg::SLOT_W-1:0]    run_first;

  // result register
  sawt_pkg::status_t              out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      connection_parity  <= 1'b0;
      ack_back_threshold <= sawt_pkg::ACK_THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sawt_pkg::CFG_CONN_PARITY: connection_parity  <= cfg_data[0];
        sawt_pkg::CFG_ACK_THRESH:  ack_back_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture
  logic [sawt_pkg::SLOT_W-1:0]      scan_first;
  logic [2*sawt_pkg::NUM_SLOTS-1:0] map_rot;

  assign scan_first = last_seq[sawt_pkg::SLOT_W-1:0] + sawt_pkg::SCAN_FIRST_OFFSET;
  assign map_rot    = {ack_map, ack_map} >> scan_first;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_seq      <= seq_low;
      in_high_ack <= partner_high_ack;
      in_conn     <= conn_bit;
      in_ping     <= is_ping;
      in_resend   <= is_resend;
      in_ackf     <= is_ack_flag;
      in_accept   <= is_accept;
      in_kind     <= header_kind;
    end
  end

  // window check
  logic [sawt_pkg::SEQ_LOW_W-1:0] diff9;
  logic                           in_window;

  assign diff9     = in_seq - last_seq[sawt_pkg::SEQ_LOW_W-1:0];
  assign in_window = (diff9 <= sawt_pkg::WINDOW_SPAN) && (last_seq <= sawt_pkg::LAST_SEQ_MAX);

  always_ff @(posedge clk) begin
    if (cmd.rx_check) begin
      rx_diff <= diff9[sawt_pkg::SLOT_W-1:0];
      if (in_conn != connection_parity) begin
        rx_code <= sawt_pkg::ST_BAD_CONN;
      end else if (!in_window) begin
        rx_code <= sawt_pkg::ST_OUT_WIN;
      end else if (diff9 == '0) begin
        rx_code <= sawt_pkg::ST_DUP;
      end else begin
        rx_code <= sawt_pkg::ST_NEW;
      end
    end
  end

  // map update
  logic [sawt_pkg::SLOT_W-1:0]    lo5;
  logic [sawt_pkg::SLOT_W-1:0]    seq5;
  logic [sawt_pkg::SLOT_W-1:0]    clr_span;
  logic [sawt_pkg::SLOT_W-1:0]    unacked;
  logic [sawt_pkg::NUM_SLOTS-1:0] clr_mask;
  logic [sawt_pkg::NUM_SLOTS-1:0] set_mask;
  logic [sawt_pkg::NUM_SLOTS-1:0] map_rx;
  logic                           rx_ok;
  logic                           rx_ack_back;

  assign lo5      = last_seq[sawt_pkg::SLOT_W-1:0];
  assign seq5     = lo5 + rx_diff;
  assign clr_span = in_high_ack - seq5;
  assign unacked  = seq5 - in_high_ack;

  always_comb begin
    logic [sawt_pkg::SLOT_W-1:0] off_gap;
    logic [sawt_pkg::SLOT_W-1:0] off_rng;
    for (int j = 0; j < sawt_pkg::NUM_SLOTS; j++) begin
      off_gap     = sawt_pkg::SLOT_W'(j) - lo5;
      off_rng     = sawt_pkg::SLOT_W'(j) - seq5 - sawt_pkg::SLOT_W'(1);
      clr_mask[j] = ((off_gap != '0) && (off_gap < rx_diff)) || (off_rng < clr_span);
    end
  end

  assign set_mask    = in_ping ? '0 : (sawt_pkg::NUM_SLOTS'(1) << seq5);
  assign map_rx      = (ack_map & ~clr_mask) | set_mask;
  assign rx_ok       = (rx_code == sawt_pkg::ST_NEW) || (rx_code == sawt_pkg::ST_DUP);
  assign rx_ack_back = rx_ok && (((in_ping || in_resend) && !in_ackf) || in_accept ||
                                 (unacked > ack_back_threshold));

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_map  <= '0;
      last_seq <= '0;
    end else if (cmd.rx_apply && rx_ok) begin
      ack_map  <= map_rx;
      last_seq <= last_seq + sawt_pkg::SEQ_W'(rx_diff);
    end
  end

  // ack run scan, one slot per step
  logic [sawt_pkg::CNT_W-1:0]  len_inc;
  logic [sawt_pkg::SLOT_W-1:0] first_inc;
  logic                        scan_emit;
  logic                        scan_last;
  logic [sawt_pkg::CNT_W-1:0]  emit_cnt;
  logic [sawt_pkg::SLOT_W-1:0] emit_start;
  logic [sawt_pkg::CNT_W-1:0]  run_len_next;
  logic [sawt_pkg::SLOT_W-1:0] run_first_next;

  assign scan_last = (scan_rem == sawt_pkg::SLOT_W'(1));
  assign len_inc   = run_len + sawt_pkg::CNT_W'(1);
  assign first_inc = (run_len == '0) ? scan_pos : run_first;

  always_comb begin
    scan_emit      = 1'b0;
    emit_cnt       = run_len;
    emit_start     = run_first;
    run_len_next   = '0;
    run_first_next = first_inc;
    if (scan_map[0]) begin
      emit_cnt   = len_inc;
      emit_start = first_inc;
      if ((len_inc == sawt_pkg::RUN_MAX) || scan_last) begin
        scan_emit = 1'b1;
      end else begin
        run_len_next = len_inc;
      end
    end else begin
      scan_emit = (run_len != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_map  <= map_rot[sawt_pkg::NUM_SLOTS-1:0];
      scan_pos  <= scan_first;
      scan_rem  <= sawt_pkg::SCAN_SLOTS;
      run_len   <= '0;
      run_first <= '0;
    end else if (cmd.scan_step) begin
      scan_map  <= scan_map >> 1;
      scan_pos  <= scan_pos + sawt_pkg::SLOT_W'(1);
      scan_rem  <= scan_rem - sawt_pkg::SLOT_W'(1);
      run_len   <= run_len_next;
      run_first <= run_first_next;
    end
  end

  // result register
  logic out_free;
  logic load_run;

  assign out_free = !out_valid || !out_stall;
  assign load_run = cmd.scan_step && scan_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rx_apply || load_run || cmd.term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_apply) begin
      out_status <= rx_code;
      ack_back   <= rx_ack_back;
      run_count  <= '0;
      run_start  <= '0;
      kind_out   <= '0;
      last       <= 1'b1;
    end else if (load_run) begin
      out_status <= sawt_pkg::ST_RUN;
      ack_back   <= 1'b0;
      run_count  <= emit_cnt;
      run_start  <= emit_start;
      kind_out   <= '0;
      last       <= 1'b0;
    end else if (cmd.term) begin
      out_status <= sawt_pkg::ST_TERM;
      ack_back   <= 1'b0;
      run_count  <= '0;
      run_start  <= '0;
      kind_out   <= in_kind;
      last       <= 1'b1;
    end
  end

  assign status        = out_status;
  assign sts.out_free  = out_free;
  assign sts.scan_emit = scan_emit;
  assign sts.scan_last = scan_last;

endmodule

// ----- design/sawt_checker.sv -----
// Port-level checker of the selective-ack window tracker and its bind.
module sawt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sawt_pkg::STATUS_W-1:0] status,
  input logic                          ack_back,
  input logic [sawt_pkg::CNT_W-1:0]    run_count,
  input logic                          last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(run_count) && $stable(last))
    else $error("stalled result beat changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat accepted while an item is in work");

  a_run_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == sawt_pkg::ST_RUN) |-> !last && !ack_back && (run_count != '0))
    else $error("malformed ack run beat");

  a_reject_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == sawt_pkg::ST_BAD_CONN) || (status == sawt_pkg::ST_OUT_WIN))
      |-> last && !ack_back && (run_count == '0))
    else $error("rejected receive beat asks for ack-back");

endmodule

bind selective_ack_window_tracker sawt_checker u_sawt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .ack_back  (ack_back),
  .run_count (run_count),
  .last      (last)
);
